[hw/rtl/slt_pkg.sv]
package slt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int KIND_BITS   = 5;
  localparam int WIN_BITS    = 48;
  localparam int KW_BYTES    = 6;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] K_END     = 5'd0;
  localparam logic [KIND_BITS-1:0] K_FN      = 5'd1;
  localparam logic [KIND_BITS-1:0] K_LET     = 5'd2;
  localparam logic [KIND_BITS-1:0] K_IF      = 5'd3;
  localparam logic [KIND_BITS-1:0] K_ELSE    = 5'd4;
  localparam logic [KIND_BITS-1:0] K_RETURN  = 5'd5;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd6;
  localparam logic [KIND_BITS-1:0] K_INTEGER = 5'd7;
  localparam logic [KIND_BITS-1:0] K_STRING  = 5'd8;
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd9;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd10;
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd11;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd12;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd13;
  localparam logic [KIND_BITS-1:0] K_COLON   = 5'd14;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd15;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd16;
  localparam logic [KIND_BITS-1:0] K_ARROW   = 5'd17;
  localparam logic [KIND_BITS-1:0] K_STAR    = 5'd18;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 5'd19;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd20;
  localparam logic [KIND_BITS-1:0] K_LE      = 5'd21;
  localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd22;
  localparam logic [KIND_BITS-1:0] K_BAD     = 5'd23;
  localparam logic [KIND_BITS-1:0] K_UNTERM  = 5'd24;

  localparam logic [WIN_BITS-1:0] KW_FN     = {32'h0, "fn"};
  localparam logic [WIN_BITS-1:0] KW_LET    = {24'h0, "let"};
  localparam logic [WIN_BITS-1:0] KW_IF     = {32'h0, "if"};
  localparam logic [WIN_BITS-1:0] KW_ELSE   = {16'h0, "else"};
  localparam logic [WIN_BITS-1:0] KW_RETURN = "return";

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } token_t;

endpackage

[hw/rtl/slt_scan.sv]
module slt_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic            mode,
  input  logic [7:0]      char_byte,
  output slt_pkg::token_t tok0,
  output slt_pkg::token_t tok1,
  output logic [1:0]      tok_cnt
);

  typedef enum logic [2:0] {
    SM_IDLE, SM_IDENT, SM_NUMBER, SM_STRING, SM_MINUS, SM_LT, SM_ERROR
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t                      mode;
    logic [slt_pkg::OFFSET_BITS-1:0] pos;
    logic [slt_pkg::OFFSET_BITS-1:0] start;
    logic [slt_pkg::LENGTH_BITS-1:0] cnt;
    logic [slt_pkg::WIN_BITS-1:0]    win;
  } scan_state_t;

  typedef struct packed {
    logic            hit;
    slt_pkg::token_t tok;
    scan_state_t     st;
  } idle_res_t;

  scan_state_t     state_r;
  scan_state_t     state_nxt;
  idle_res_t       idle_v;
  logic            pend_hit;
  slt_pkg::token_t pend_tok;
  logic            sec_hit;
  slt_pkg::token_t sec_tok;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic slt_pkg::token_t mk_tok(input logic [slt_pkg::KIND_BITS-1:0] kind,
                                             input logic [slt_pkg::OFFSET_BITS-1:0] off,
                                             input logic [slt_pkg::LENGTH_BITS-1:0] len);
    slt_pkg::token_t t;
    t.kind   = kind;
    t.offset = off;
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic scan_state_t count_byte(input scan_state_t s, input logic [7:0] c);
    scan_state_t r;
    r = s;
    if (s.cnt < slt_pkg::LENGTH_BITS'(slt_pkg::KW_BYTES)) begin
      r.win = {s.win[slt_pkg::WIN_BITS-9:0], c};
    end
    if (s.cnt != slt_pkg::LEN_MAX) begin
      r.cnt = s.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [slt_pkg::KIND_BITS-1:0] ident_kind(input scan_state_t s);
    logic [slt_pkg::KIND_BITS-1:0] k;
    k = slt_pkg::K_IDENT;
    if (s.cnt == 2 && s.win == slt_pkg::KW_FN) k = slt_pkg::K_FN;
    else if (s.cnt == 3 && s.win == slt_pkg::KW_LET) k = slt_pkg::K_LET;
    else if (s.cnt == 2 && s.win == slt_pkg::KW_IF) k = slt_pkg::K_IF;
    else if (s.cnt == 4 && s.win == slt_pkg::KW_ELSE) k = slt_pkg::K_ELSE;
    else if (s.cnt == 6 && s.win == slt_pkg::KW_RETURN) k = slt_pkg::K_RETURN;
    return k;
  endfunction

  function automatic idle_res_t idle_scan(input scan_state_t s, input logic [7:0] c);
    idle_res_t                     r;
    logic [slt_pkg::KIND_BITS-1:0] k;
    logic                          punct;
    r.hit     = 1'b0;
    r.st      = s;
    r.st.mode = SM_IDLE;
    punct     = 1'b1;
    case (c)
      "(":     k = slt_pkg::K_LPAREN;
      ")":     k = slt_pkg::K_RPAREN;
      "{":     k = slt_pkg::K_LBRACE;
      "}":     k = slt_pkg::K_RBRACE;
      ",":     k = slt_pkg::K_COMMA;
      ":":     k = slt_pkg::K_COLON;
      "+":     k = slt_pkg::K_PLUS;
      "*":     k = slt_pkg::K_STAR;
      "/":     k = slt_pkg::K_SLASH;
      "=":     k = slt_pkg::K_ASSIGN;
      ";":     k = slt_pkg::K_SEMI;
      default: begin
        k     = slt_pkg::K_BAD;
        punct = 1'b0;
      end
    endcase
    r.tok = mk_tok(k, s.pos, slt_pkg::LENGTH_BITS'(1));
    if (is_space(c)) begin
      r.hit = 1'b0;
    end else if (punct) begin
      r.hit = 1'b1;
    end else if (c == "-" || c == "<" || c == 8'h22) begin
      r.st.mode  = (c == "-") ? SM_MINUS : ((c == "<") ? SM_LT : SM_STRING);
      r.st.start = (c == 8'h22) ? s.pos + 1'b1 : s.pos;
      r.st.cnt   = '0;
      r.st.win   = '0;
    end else if (is_alpha(c) || c == "_" || is_digit(c)) begin
      r.st.mode  = is_digit(c) ? SM_NUMBER : SM_IDENT;
      r.st.start = s.pos;
      r.st.cnt   = slt_pkg::LENGTH_BITS'(1);
      r.st.win   = {{(slt_pkg::WIN_BITS-8){1'b0}}, c};
    end else begin
      r.hit     = 1'b1;
      r.st.mode = SM_ERROR;
    end
    return r;
  endfunction

  always_comb begin
    idle_v    = idle_scan(state_r, char_byte);
    state_nxt = state_r;
    pend_hit  = 1'b0;
    pend_tok  = '0;
    sec_hit   = 1'b0;
    sec_tok   = '0;
    if (mode) begin
      pend_hit = 1'b1;
      case (state_r.mode)
        SM_IDENT:  pend_tok = mk_tok(ident_kind(state_r), state_r.start, state_r.cnt);
        SM_NUMBER: pend_tok = mk_tok(slt_pkg::K_INTEGER, state_r.start, state_r.cnt);
        SM_STRING: pend_tok = mk_tok(slt_pkg::K_UNTERM, state_r.start, state_r.cnt);
        SM_MINUS:  pend_tok = mk_tok(slt_pkg::K_MINUS, state_r.start,
                                     slt_pkg::LENGTH_BITS'(1));
        SM_LT:     pend_tok = mk_tok(slt_pkg::K_BAD, state_r.start,
                                     slt_pkg::LENGTH_BITS'(1));
        default:   pend_hit = 1'b0;
      endcase
      sec_hit   = 1'b1;
      sec_tok   = mk_tok(slt_pkg::K_END, state_r.pos, '0);
      state_nxt = '{mode: SM_IDLE, default: '0};
    end else begin
      case (state_r.mode)
        SM_IDENT: begin
          if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == "_") begin
            state_nxt = count_byte(state_r, char_byte);
          end else begin
            pend_hit  = 1'b1;
            pend_tok  = mk_tok(ident_kind(state_r), state_r.start, state_r.cnt);
            sec_hit   = idle_v.hit;
            sec_tok   = idle_v.tok;
            state_nxt = idle_v.st;
          end
        end
        SM_NUMBER: begin
          if (is_digit(char_byte)) begin
            state_nxt = count_byte(state_r, char_byte);
          end else begin
            pend_hit  = 1'b1;
            pend_tok  = mk_tok(slt_pkg::K_INTEGER, state_r.start, state_r.cnt);
            sec_hit   = idle_v.hit;
            sec_tok   = idle_v.tok;
            state_nxt = idle_v.st;
          end
        end
        SM_STRING: begin
          if (char_byte == 8'h22) begin
            pend_hit       = 1'b1;
            pend_tok       = mk_tok(slt_pkg::K_STRING, state_r.start, state_r.cnt);
            state_nxt.mode = SM_IDLE;
          end else if (state_r.cnt != slt_pkg::LEN_MAX) begin
            state_nxt.cnt = state_r.cnt + 1'b1;
          end
        end
        SM_MINUS: begin
          pend_hit = 1'b1;
          if (char_byte == ">") begin
            pend_tok       = mk_tok(slt_pkg::K_ARROW, state_r.start,
                                    slt_pkg::LENGTH_BITS'(2));
            state_nxt.mode = SM_IDLE;
          end else begin
            pend_tok  = mk_tok(slt_pkg::K_MINUS, state_r.start, slt_pkg::LENGTH_BITS'(1));
            sec_hit   = idle_v.hit;
            sec_tok   = idle_v.tok;
            state_nxt = idle_v.st;
          end
        end
        SM_LT: begin
          pend_hit = 1'b1;
          if (char_byte == "=") begin
            pend_tok       = mk_tok(slt_pkg::K_LE, state_r.start, slt_pkg::LENGTH_BITS'(2));
            state_nxt.mode = SM_IDLE;
          end else begin
            pend_tok       = mk_tok(slt_pkg::K_BAD, state_r.start, slt_pkg::LENGTH_BITS'(1));
            state_nxt.mode = SM_ERROR;
          end
        end
        SM_ERROR: begin
          state_nxt.mode = SM_ERROR;
        end
        default: begin
          sec_hit   = idle_v.hit;
          sec_tok   = idle_v.tok;
          state_nxt = idle_v.st;
        end
      endcase
      state_nxt.pos = state_r.pos + 1'b1;
    end

    if (pend_hit) begin
      tok0    = pend_tok;
      tok1    = sec_tok;
      tok_cnt = sec_hit ? 2'd2 : 2'd1;
    end else begin
      tok0    = sec_tok;
      tok1    = '0;
      tok_cnt = sec_hit ? 2'd1 : 2'd0;
    end
    if (tok_cnt == 2'd2) begin
      tok1.last = 1'b1;
    end else begin
      tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: SM_IDLE, default: '0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/slt_outq.sv]
module slt_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [1:0]                          push_cnt,
  input  slt_pkg::token_t                     tok0,
  input  slt_pkg::token_t                     tok1,
  output logic                                room,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slt_pkg::KIND_BITS-1:0]       out_token_kind,
  output logic [slt_pkg::OFFSET_BITS-1:0]     out_start_offset,
  output logic [slt_pkg::LENGTH_BITS-1:0]     out_token_length,
  output logic                                out_last
);

  slt_pkg::token_t                 mem_r [slt_pkg::Q_DEPTH];
  logic [slt_pkg::Q_PTR_BITS-1:0]  wr_ptr_r;
  logic [slt_pkg::Q_PTR_BITS-1:0]  wr_ptr_nxt;
  logic [slt_pkg::Q_PTR_BITS-1:0]  rd_ptr_r;
  logic [slt_pkg::Q_PTR_BITS-1:0]  rd_ptr_nxt;
  logic [slt_pkg::Q_CNT_BITS-1:0]  count_r;
  logic [slt_pkg::Q_CNT_BITS-1:0]  count_nxt;
  logic [slt_pkg::Q_CNT_BITS-1:0]  add_cnt;
  logic                            pop;
  slt_pkg::token_t                 head;

  assign room      = count_r <= slt_pkg::Q_CNT_BITS'(slt_pkg::Q_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_ptr_r];

  assign out_token_kind   = head.kind;
  assign out_start_offset = head.offset;
  assign out_token_length = head.length;
  assign out_last         = head.last;

  always_comb begin
    add_cnt    = push ? slt_pkg::Q_CNT_BITS'(push_cnt) : '0;
    wr_ptr_nxt = wr_ptr_r + slt_pkg::Q_PTR_BITS'(add_cnt);
    rd_ptr_nxt = rd_ptr_r + slt_pkg::Q_PTR_BITS'(pop);
    count_nxt  = count_r + add_cnt - slt_pkg::Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= tok0;
    end
    if (push && push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= tok1;
    end
  end

endmodule

[hw/rtl/source_lexer_tokenizer.sv]
// Streaming lexer: one source byte or end marker per input transfer, up to two tokens out.
// Each token is written into the registered token queue and offered on the output from there, behind earlier tokens.
// Throughput: one input transfer per cycle while the four-entry token queue has room
// for two tokens; the output drains one token per cycle while out_stall is low.
// Reset: synchronous active-low rst_n returns the scanner to idle at offset zero and empties the queue.
module source_lexer_tokenizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [7:0]                      in_char_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slt_pkg::KIND_BITS-1:0]   out_token_kind,
  output logic [slt_pkg::OFFSET_BITS-1:0] out_start_offset,
  output logic [slt_pkg::LENGTH_BITS-1:0] out_token_length,
  output logic                            out_last
);

  logic            in_fire;
  logic            room;
  slt_pkg::token_t tok0;
  slt_pkg::token_t tok1;
  logic [1:0]      tok_cnt;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  slt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .mode      (in_mode),
    .char_byte (in_char_byte),
    .tok0      (tok0),
    .tok1      (tok1),
    .tok_cnt   (tok_cnt)
  );

  slt_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (in_fire),
    .push_cnt         (tok_cnt),
    .tok0             (tok0),
    .tok1             (tok1),
    .room             (room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

endmodule

[hw/rtl/slt_checker.sv]
module slt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [slt_pkg::KIND_BITS-1:0]   out_token_kind,
  input logic [slt_pkg::OFFSET_BITS-1:0] out_start_offset,
  input logic [slt_pkg::LENGTH_BITS-1:0] out_token_length,
  input logic                            out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_start_offset) && $stable(out_token_length) && $stable(out_last))
    else $error("Stalled output transfer changed.");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == slt_pkg::K_END |-> out_last && out_token_length == '0)
    else $error("End token must close its group and carry zero length.");

  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == slt_pkg::K_BAD |-> out_token_length == 1)
    else $error("Bad character token must have length one.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Queue not empty after reset.");

endmodule

bind source_lexer_tokenizer slt_checker u_slt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_token_kind   (out_token_kind),
  .out_start_offset (out_start_offset),
  .out_token_length (out_token_length),
  .out_last         (out_last)
);
